FILE: rtl/bdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce, long press and
// auto-repeat block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned CNT_W = 8;
  localparam int unsigned BTN_N = 4;

  localparam logic [CNT_W-1:0] CAP_EXTRA    = 8'd5;
  localparam logic [CNT_W-1:0] DECAY_FLOOR  = 8'd3;
  localparam logic [CNT_W-1:0] PRESS_LEVEL  = 8'd2;
  localparam logic [CNT_W-1:0] RELOAD_COUNT = 8'd5;
  localparam logic [CNT_W-1:0] REARM_LONG   = 8'd5;
  localparam logic [CNT_W-1:0] REARM_SHORT  = 8'd2;

  localparam logic [CNT_W-1:0] LONG_TICKS_RST   = 8'd200;
  localparam logic [CNT_W-1:0] REPEAT_TICKS_RST = 8'd50;

  localparam logic REG_LONG_PRESS_TICKS = 1'b0;
  localparam logic REG_REPEAT_TICKS     = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             short_done;
    logic             long_done;
    logic             rep_mode;
  } press_state_t;

endpackage

FILE: rtl/bdlp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_step
// One sampling tick: count update, press and threshold events, rearm.
// ----------------------------------------------------------------------------
module bdlp_step
  import bdlp_pkg::*;
(
  input  press_state_t     st,
  input  logic [BTN_N-1:0] held,
  input  logic [CNT_W-1:0] long_ticks,
  input  logic [CNT_W-1:0] repeat_ticks,
  output press_state_t     st_nxt,
  output logic [BTN_N-1:0] events
);

  logic [CNT_W-1:0] thr;
  logic [CNT_W:0]   cap_sum;
  logic [CNT_W-1:0] cap;
  logic             any_held;
  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] cnt2;
  logic             short_fire;
  logic             long_fire;

  assign thr      = st.rep_mode ? repeat_ticks : long_ticks;
  assign cap_sum  = {1'b0, thr} + {1'b0, CAP_EXTRA};
  assign cap      = cap_sum[CNT_W] ? {CNT_W{1'b1}} : cap_sum[CNT_W-1:0];
  assign any_held = |held;

  always_comb begin
    priority if (any_held && (st.cnt < cap)) begin
      cnt1 = st.cnt + 8'd1;
    end else if (st.cnt > DECAY_FLOOR) begin
      cnt1 = DECAY_FLOOR;
    end else if (st.cnt != '0) begin
      cnt1 = st.cnt - 8'd1;
    end else begin
      cnt1 = st.cnt;
    end
  end

  assign short_fire = (cnt1 > PRESS_LEVEL) && !st.short_done && any_held;
  assign long_fire  = (cnt1 > thr) && !st.long_done;
  assign cnt2       = long_fire ? RELOAD_COUNT : cnt1;
  assign events     = (short_fire || long_fire) ? held : '0;

  always_comb begin
    st_nxt.cnt        = cnt2;
    st_nxt.short_done = (st.short_done | short_fire) & ~(cnt2 < REARM_SHORT);
    st_nxt.rep_mode   = (st.rep_mode | long_fire) & ~(cnt2 < REARM_SHORT);
    st_nxt.long_done  = (st.long_done | long_fire) & ~(cnt2 < REARM_LONG);
  end

endmodule

FILE: rtl/button_debounce_long_press_repeat_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_top
// Four-button debouncer with shared press counter, long press and repeat.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      request in valid / ready      left/right/up/down_pressed
// out_     result out valid / ready      left/right/up/down_event, repeat_active
// cfg_     write in   cfg_we             cfg_index, cfg_data
//
// One request per clock while in_ready is high; its result is registered and shown the next cycle.
// in_ready is low only while a result is held and out_ready is low.
// Reset (synchronous, rst_n low) clears the count and flags and restores the
// default thresholds.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat_top
  import bdlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_left_pressed,
  input  logic             in_right_pressed,
  input  logic             in_up_pressed,
  input  logic             in_down_pressed,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_left_event,
  output logic             out_right_event,
  output logic             out_up_event,
  output logic             out_down_event,
  output logic             out_repeat_active,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  press_state_t     st_r;
  press_state_t     st_nxt;
  logic [CNT_W-1:0] long_ticks_r;
  logic [CNT_W-1:0] repeat_ticks_r;
  logic [BTN_N-1:0] held;
  logic [BTN_N-1:0] events;
  logic [BTN_N-1:0] events_r;
  logic             rep_r;
  logic             out_valid_r;
  logic             in_fire;

  assign held     = {in_down_pressed, in_up_pressed, in_right_pressed, in_left_pressed};
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  bdlp_step u_step (
    .st           (st_r),
    .held         (held),
    .long_ticks   (long_ticks_r),
    .repeat_ticks (repeat_ticks_r),
    .st_nxt       (st_nxt),
    .events       (events)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r   <= LONG_TICKS_RST;
      repeat_ticks_r <= REPEAT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS_TICKS: long_ticks_r   <= cfg_data;
        REG_REPEAT_TICKS:     repeat_ticks_r <= cfg_data;
        default:              long_ticks_r   <= long_ticks_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      events_r <= events;
      rep_r    <= st_nxt.rep_mode;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_event    = events_r[0];
  assign out_right_event   = events_r[1];
  assign out_up_event      = events_r[2];
  assign out_down_event    = events_r[3];
  assign out_repeat_active = rep_r;

  a_short_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cnt < REARM_SHORT) |-> (!st_r.short_done && !st_r.rep_mode))
    else $error("short flag or repeat mode set at low count");

  a_long_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cnt < REARM_LONG) |-> !st_r.long_done)
    else $error("long flag set below rearm level");

  a_no_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (held == '0)) |=> (events_r == '0))
    else $error("event raised with no button held");

  a_repeat_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (rep_r == st_r.rep_mode))
    else $error("repeat_active disagrees with state");

endmodule
